// ===== src/bsw_pkg.sv =====
// Shared types, constants and the brush recipe lookup for the brush stamp width core.
package bsw_pkg;

    // Beat layout of the input and result channels.
    localparam int S_TDATA_W  = 120;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 16;

    localparam int THICK_LSB  = 0;
    localparam int INDEX_LSB  = 10;
    localparam int COUNT_LSB  = 21;
    localparam int SPEED_LSB  = 33;
    localparam int SSEED_LSB  = 49;
    localparam int FSEED_LSB  = 81;

    // Brush recipe codes as carried on s_tuser.
    localparam logic [1:0] BRUSH_INK       = 2'd0;
    localparam logic [1:0] BRUSH_PEN       = 2'd1;
    localparam logic [1:0] BRUSH_FINELINER = 2'd2;
    localparam logic [1:0] BRUSH_MARKER    = 2'd3;

    // Largest stroke length; longer counts are saturated to it.
    localparam logic [11:0] MAX_POINTS = 12'd2048;

    // Fixed-point constants.
    localparam logic [16:0] ONE_Q16    = 17'h10000;
    localparam logic [15:0] HALF_Q16   = 16'h8000;
    localparam logic [17:0] THREE_Q16  = 18'd196608;
    localparam logic [12:0] WIDTH_MAX  = 13'd8191;

    // Hash constants.
    localparam logic [31:0] HASH_C1    = 32'h7feb352d;
    localparam logic [31:0] HASH_C2    = 32'h846ca68b;
    localparam logic [31:0] IDX_GOLDEN = 32'h9e3779b1;

    // Fractional divider: 16 quotient bits, two per register stage.
    localparam int DIV_W          = 16;
    localparam int DIV_STAGES     = 8;
    localparam int BITS_PER_STAGE = DIV_W / DIV_STAGES;

    // Pipeline register stages of the top level.
    localparam int ST_IN   = 0;
    localparam int ST_PREP = 1;
    localparam int ST_H2   = 2;
    localparam int ST_H3   = 3;
    localparam int ST_WOB  = 4;
    localparam int ST_T    = ST_PREP + DIV_STAGES + 1;
    localparam int ST_BASE = ST_T + 1;
    localparam int ST_SCL  = ST_T + 2;
    localparam int ST_X    = ST_T + DIV_STAGES + 1;
    localparam int ST_SS   = ST_X + 1;
    localparam int ST_W1   = ST_X + 2;
    localparam int ST_W2   = ST_X + 3;
    localparam int ST_OUT  = ST_X + 4;
    localparam int NST     = ST_OUT + 1;

    // Brush recipe: widths and speed reference Q8.8, noise and taper Q0.16.
    typedef struct packed {
        logic [11:0] minw;
        logic [11:0] maxw;
        logic [12:0] sref;
        logic [14:0] noise;
        logic [13:0] tap;
    } recipe_t;

    // Everything one point carries down the pipeline.
    typedef struct packed {
        logic [1:0]  sel;
        logic [9:0]  thick;
        logic [10:0] idx;
        logic [11:0] cnt;
        logic [15:0] spd;
        logic [31:0] hash;
        logic        single;
        logic        at_end;
        logic        spd_sat;
        logic [11:0] minw;
        logic [11:0] maxw;
        logic [12:0] sref;
        logic [14:0] noise;
        logic [13:0] tap;
        logic [15:0] t_num;
        logic [15:0] t_den;
        logic [15:0] s_num;
        logic        tap_clamp;
        logic [15:0] tap_num;
        logic [16:0] ratio;
        logic [27:0] base;
        logic [21:0] scaled;
        logic [16:0] wob;
        logic [16:0] x;
        logic [16:0] s2;
        logic [16:0] ss;
        logic [21:0] w1;
        logic [22:0] w2;
        logic [12:0] width;
    } pipe_t;

    // Recipe table: ink, pen, fineliner, marker.
    function automatic recipe_t recipe_lookup(input logic [1:0] sel);
        recipe_t r;
        case (sel)
            BRUSH_INK:       r = '{minw: 12'd461,  maxw: 12'd2304, sref: 13'd2304,
                                   noise: 15'd9830,  tap: 14'd9175};
            BRUSH_PEN:       r = '{minw: 12'd256,  maxw: 12'd666,  sref: 13'd1536,
                                   noise: 15'd22938, tap: 14'd6554};
            BRUSH_FINELINER: r = '{minw: 12'd307,  maxw: 12'd486,  sref: 13'd3072,
                                   noise: 15'd3277,  tap: 14'd5243};
            default:         r = '{minw: 12'd1280, maxw: 12'd1920, sref: 13'd5632,
                                   noise: 15'd3277,  tap: 14'd3277};
        endcase
        return r;
    endfunction

endpackage

// ===== src/bsw_qdiv.sv =====
// Pipelined restoring divider giving floor(num * 2^16 / den) for num below den.
module bsw_qdiv (
    input  logic                                aclk,
    input  logic [bsw_pkg::DIV_STAGES-1:0]      stage_en,
    input  logic [bsw_pkg::DIV_W-1:0]           num_i,
    input  logic [bsw_pkg::DIV_W-1:0]           den_i,
    output logic [bsw_pkg::DIV_W-1:0]           quo_o
);

    logic [bsw_pkg::DIV_W-1:0] rem_reg  [bsw_pkg::DIV_STAGES];
    logic [bsw_pkg::DIV_W-1:0] den_reg  [bsw_pkg::DIV_STAGES];
    logic [bsw_pkg::DIV_W-1:0] quo_reg  [bsw_pkg::DIV_STAGES];
    logic [bsw_pkg::DIV_W-1:0] rem_in   [bsw_pkg::DIV_STAGES];
    logic [bsw_pkg::DIV_W-1:0] den_in   [bsw_pkg::DIV_STAGES];
    logic [bsw_pkg::DIV_W-1:0] quo_in   [bsw_pkg::DIV_STAGES];
    logic [bsw_pkg::DIV_W-1:0] rem_next [bsw_pkg::DIV_STAGES];
    logic [bsw_pkg::DIV_W-1:0] quo_next [bsw_pkg::DIV_STAGES];

    // Each stage takes its operands from the stage before it.
    always_comb begin
        rem_in[0] = num_i;
        den_in[0] = den_i;
        quo_in[0] = '0;
        for (int j = 1; j < bsw_pkg::DIV_STAGES; j++) begin
            rem_in[j] = rem_reg[j-1];
            den_in[j] = den_reg[j-1];
            quo_in[j] = quo_reg[j-1];
        end
    end

    // Shift, compare and subtract, a few quotient bits per stage.
    always_comb begin
        logic [bsw_pkg::DIV_W:0]   sh;
        logic [bsw_pkg::DIV_W-1:0] r;
        logic [bsw_pkg::DIV_W-1:0] q;
        for (int j = 0; j < bsw_pkg::DIV_STAGES; j++) begin
            r = rem_in[j];
            q = quo_in[j];
            for (int b = 0; b < bsw_pkg::BITS_PER_STAGE; b++) begin
                sh = {r, 1'b0};
                if (sh >= {1'b0, den_in[j]}) begin
                    sh = sh - {1'b0, den_in[j]};
                    q  = {q[bsw_pkg::DIV_W-2:0], 1'b1};
                end else begin
                    q  = {q[bsw_pkg::DIV_W-2:0], 1'b0};
                end
                r = sh[bsw_pkg::DIV_W-1:0];
            end
            rem_next[j] = r;
            quo_next[j] = q;
        end
    end

    // Stage registers move with the pipeline enables of the top level.
    always_ff @(posedge aclk) begin
        for (int j = 0; j < bsw_pkg::DIV_STAGES; j++) begin
            if (stage_en[j]) begin
                rem_reg[j] <= rem_next[j];
                den_reg[j] <= den_in[j];
                quo_reg[j] <= quo_next[j];
            end
        end
    end

    assign quo_o = quo_reg[bsw_pkg::DIV_STAGES-1];

endmodule

// ===== src/brush_stamp_width_core.sv =====
// Top level of the brush stamp width core: a 24-stage pipeline, one point per beat.
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+-------------------------------------------------
//   input    | s_tvalid, s_tready | s_tdata (point fields), s_tuser (brush select)
//   result   | m_tvalid, m_tready | m_tdata (stamp width)
//
// One point enters per cycle while s_tready is high; its width leaves from the last stage.
// The depth is set by the two 8-stage fractional dividers in series (stroke
// position, then taper) plus the input, recipe, position and multiply stages around them.
// aresetn is synchronous and clears only the stage valid bits.
// A stalled result holds in the last stage; empty stages ahead of it keep
// filling, so s_tready stays high until every stage holds a point.
module brush_stamp_width_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // thickness, point_index, point_count, speed, stroke_seed, frame_seed, zero pad
    input  logic [bsw_pkg::S_TDATA_W-1:0]   s_tdata,
    // brush_select
    input  logic [bsw_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // width, zero pad
    output logic [bsw_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic [bsw_pkg::NST-1:0] v_reg;
    logic [bsw_pkg::NST-1:0] adv;
    bsw_pkg::pipe_t          p_reg  [bsw_pkg::NST];
    bsw_pkg::pipe_t          p_next [bsw_pkg::NST];

    logic [bsw_pkg::DIV_W-1:0] q_t;
    logic [bsw_pkg::DIV_W-1:0] q_s;
    logic [bsw_pkg::DIV_W-1:0] q_tap;

    // A stage may load when the result is taken or when it or any stage after it is empty.
    always_comb begin
        for (int k = 0; k < bsw_pkg::NST; k++) begin
            adv[k] = m_tready ||
                     (~(v_reg | bsw_pkg::NST'((64'd1 << k) - 64'd1)) != '0);
        end
    end

    assign s_tready = adv[bsw_pkg::ST_IN];

    // Valid bits follow the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) begin
                v_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < bsw_pkg::NST; k++) begin
                if (adv[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < bsw_pkg::NST; k++) begin
            if (adv[k]) begin
                p_reg[k] <= p_next[k];
            end
        end
    end

    // Stage logic. Each stage passes the point on and works out its own fields.
    always_comb begin
        bsw_pkg::recipe_t rc;
        logic [11:0]  cnt_in;
        logic [10:0]  idx_in;
        logic [31:0]  hv;
        logic [38:0]  frac_prod;
        logic [17:0]  wob_sum;
        logic [15:0]  tq;
        logic [16:0]  om;
        logic [15:0]  d;
        logic [28:0]  diff_prod;
        logic [37:0]  sc_prod;
        logic [16:0]  xv;
        logic [33:0]  x_prod;
        logic [17:0]  fac;
        logic [34:0]  ss_prod;
        logic [38:0]  w1_prod;
        logic [38:0]  w2_prod;
        logic [14:0]  w_sh;

        for (int k = 1; k < bsw_pkg::NST; k++) begin
            p_next[k] = p_reg[k-1];
        end

        // Input beat: unpack, saturate the count and form the hash key.
        p_next[bsw_pkg::ST_IN] = '0;
        idx_in = s_tdata[bsw_pkg::INDEX_LSB +: 11];
        cnt_in = s_tdata[bsw_pkg::COUNT_LSB +: 12];
        p_next[bsw_pkg::ST_IN].sel   = s_tuser[1:0];
        p_next[bsw_pkg::ST_IN].thick = s_tdata[bsw_pkg::THICK_LSB +: 10];
        p_next[bsw_pkg::ST_IN].idx   = idx_in;
        p_next[bsw_pkg::ST_IN].cnt   = (cnt_in > bsw_pkg::MAX_POINTS) ?
                                       bsw_pkg::MAX_POINTS : cnt_in;
        p_next[bsw_pkg::ST_IN].spd   = s_tdata[bsw_pkg::SPEED_LSB +: 16];
        p_next[bsw_pkg::ST_IN].hash  = s_tdata[bsw_pkg::SSEED_LSB +: 32] ^
                                       s_tdata[bsw_pkg::FSEED_LSB +: 32] ^
                                       32'(32'(idx_in) * bsw_pkg::IDX_GOLDEN);

        // Recipe lookup, special cases, divider operands, first hash round.
        rc = bsw_pkg::recipe_lookup(p_reg[bsw_pkg::ST_IN].sel);
        p_next[bsw_pkg::ST_PREP].minw  = rc.minw;
        p_next[bsw_pkg::ST_PREP].maxw  = rc.maxw;
        p_next[bsw_pkg::ST_PREP].sref  = rc.sref;
        p_next[bsw_pkg::ST_PREP].noise = rc.noise;
        p_next[bsw_pkg::ST_PREP].tap   = rc.tap;
        p_next[bsw_pkg::ST_PREP].single = (p_reg[bsw_pkg::ST_IN].cnt <= 12'd1);
        p_next[bsw_pkg::ST_PREP].at_end = (p_reg[bsw_pkg::ST_IN].cnt > 12'd1) &&
            ({1'b0, p_reg[bsw_pkg::ST_IN].idx} >= (p_reg[bsw_pkg::ST_IN].cnt - 12'd1));
        p_next[bsw_pkg::ST_PREP].spd_sat =
            (p_reg[bsw_pkg::ST_IN].spd >= 16'(rc.sref));
        p_next[bsw_pkg::ST_PREP].t_num =
            (p_next[bsw_pkg::ST_PREP].single || p_next[bsw_pkg::ST_PREP].at_end) ?
            16'd0 : 16'(p_reg[bsw_pkg::ST_IN].idx);
        p_next[bsw_pkg::ST_PREP].t_den = 16'(p_reg[bsw_pkg::ST_IN].cnt - 12'd1);
        p_next[bsw_pkg::ST_PREP].s_num =
            p_next[bsw_pkg::ST_PREP].spd_sat ? 16'd0 : p_reg[bsw_pkg::ST_IN].spd;
        hv = p_reg[bsw_pkg::ST_IN].hash ^ (p_reg[bsw_pkg::ST_IN].hash >> 16);
        p_next[bsw_pkg::ST_PREP].hash = hv * bsw_pkg::HASH_C1;

        // Second hash round.
        hv = p_reg[bsw_pkg::ST_PREP].hash ^ (p_reg[bsw_pkg::ST_PREP].hash >> 15);
        p_next[bsw_pkg::ST_H2].hash = hv * bsw_pkg::HASH_C2;

        // Hash finish, keep the low 24 bits as the noise fraction.
        hv = p_reg[bsw_pkg::ST_H2].hash ^ (p_reg[bsw_pkg::ST_H2].hash >> 16);
        p_next[bsw_pkg::ST_H3].hash = {8'd0, hv[23:0]};

        // Wobble factor 1 - noise + frac * noise * 2, in Q16.
        frac_prod = 39'(p_reg[bsw_pkg::ST_H3].hash[23:0]) *
                    39'(p_reg[bsw_pkg::ST_H3].noise);
        wob_sum   = 18'(bsw_pkg::ONE_Q16) - 18'(p_reg[bsw_pkg::ST_H3].noise) +
                    18'(frac_prod >> 23);
        p_next[bsw_pkg::ST_WOB].wob = wob_sum[16:0];

        // Position, distance to the nearer end, and the speed ratio.
        tq = p_reg[bsw_pkg::ST_T-1].single ? bsw_pkg::HALF_Q16 : q_t;
        om = bsw_pkg::ONE_Q16 - {1'b0, tq};
        if (p_reg[bsw_pkg::ST_T-1].at_end) begin
            d = 16'd0;
        end else if (tq <= bsw_pkg::HALF_Q16) begin
            d = tq;
        end else begin
            d = om[15:0];
        end
        p_next[bsw_pkg::ST_T].tap_clamp = (d >= 16'(p_reg[bsw_pkg::ST_T-1].tap));
        p_next[bsw_pkg::ST_T].tap_num   =
            p_next[bsw_pkg::ST_T].tap_clamp ? 16'd0 : d;
        p_next[bsw_pkg::ST_T].ratio     =
            p_reg[bsw_pkg::ST_T-1].spd_sat ? bsw_pkg::ONE_Q16 : {1'b0, q_s};

        // Speed blend from maximum to minimum width, Q4.24.
        diff_prod = 29'(p_reg[bsw_pkg::ST_T].maxw - p_reg[bsw_pkg::ST_T].minw) *
                    29'(p_reg[bsw_pkg::ST_T].ratio);
        p_next[bsw_pkg::ST_BASE].base = {p_reg[bsw_pkg::ST_T].maxw, 16'd0} -
                                        diff_prod[27:0];

        // Thickness scaling.
        sc_prod = 38'(p_reg[bsw_pkg::ST_BASE].base) *
                  38'(p_reg[bsw_pkg::ST_BASE].thick);
        p_next[bsw_pkg::ST_SCL].scaled = sc_prod[37:16];

        // Taper factor and its square.
        xv = p_reg[bsw_pkg::ST_X-1].tap_clamp ? bsw_pkg::ONE_Q16 : {1'b0, q_tap};
        x_prod = 34'(xv) * 34'(xv);
        p_next[bsw_pkg::ST_X].x  = xv;
        p_next[bsw_pkg::ST_X].s2 = x_prod[32:16];

        // Smoothstep x^2 (3 - 2x).
        fac     = bsw_pkg::THREE_Q16 - {p_reg[bsw_pkg::ST_X].x, 1'b0};
        ss_prod = 35'(p_reg[bsw_pkg::ST_X].s2) * 35'(fac);
        p_next[bsw_pkg::ST_SS].ss = ss_prod[32:16];

        // Apply the taper.
        w1_prod = 39'(p_reg[bsw_pkg::ST_SS].scaled) * 39'(p_reg[bsw_pkg::ST_SS].ss);
        p_next[bsw_pkg::ST_W1].w1 = w1_prod[37:16];

        // Apply the wobble.
        w2_prod = 39'(p_reg[bsw_pkg::ST_W1].w1) * 39'(p_reg[bsw_pkg::ST_W1].wob);
        p_next[bsw_pkg::ST_W2].w2 = w2_prod[38:16];

        // Back to Q8.8 and saturate.
        w_sh = p_reg[bsw_pkg::ST_W2].w2[22:8];
        p_next[bsw_pkg::ST_OUT].width = (w_sh > 15'(bsw_pkg::WIDTH_MAX)) ?
                                        bsw_pkg::WIDTH_MAX : w_sh[12:0];
    end

    // Stroke position t = index / (count - 1).
    bsw_qdiv u_div_pos (
        .aclk     (aclk),
        .stage_en (adv[bsw_pkg::ST_PREP+1 +: bsw_pkg::DIV_STAGES]),
        .num_i    (p_reg[bsw_pkg::ST_PREP].t_num),
        .den_i    (p_reg[bsw_pkg::ST_PREP].t_den),
        .quo_o    (q_t)
    );

    // Speed over the recipe's speed reference.
    bsw_qdiv u_div_speed (
        .aclk     (aclk),
        .stage_en (adv[bsw_pkg::ST_PREP+1 +: bsw_pkg::DIV_STAGES]),
        .num_i    (p_reg[bsw_pkg::ST_PREP].s_num),
        .den_i    (16'(p_reg[bsw_pkg::ST_PREP].sref)),
        .quo_o    (q_s)
    );

    // End distance over the recipe's taper fraction.
    bsw_qdiv u_div_taper (
        .aclk     (aclk),
        .stage_en (adv[bsw_pkg::ST_T+1 +: bsw_pkg::DIV_STAGES]),
        .num_i    (p_reg[bsw_pkg::ST_T].tap_num),
        .den_i    (16'(p_reg[bsw_pkg::ST_T].tap)),
        .quo_o    (q_tap)
    );

    assign m_tvalid = v_reg[bsw_pkg::ST_OUT];
    assign m_tdata  = {3'd0, p_reg[bsw_pkg::ST_OUT].width};

    // An accepted beat always lands in the first stage.
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v_reg[bsw_pkg::ST_IN])
        else $error("accepted beat did not enter the pipeline");

    // A one-point stroke always gets the full taper.
    a_single_full: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[bsw_pkg::ST_X] && p_reg[bsw_pkg::ST_X].single |->
        p_reg[bsw_pkg::ST_X].x == bsw_pkg::ONE_Q16)
        else $error("single-point stroke lost its taper");

    // The smoothstep never exceeds one.
    a_ss_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[bsw_pkg::ST_SS] |-> p_reg[bsw_pkg::ST_SS].ss <= bsw_pkg::ONE_Q16)
        else $error("smoothstep above one");

    // A point at or past the stroke end has zero width.
    a_end_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[bsw_pkg::ST_OUT] && p_reg[bsw_pkg::ST_OUT].at_end |->
        p_reg[bsw_pkg::ST_OUT].width == 13'd0)
        else $error("end point has non-zero width");

endmodule
